// ===== rtl/core/variable_rate_linear_resampler_core_macros.svh =====
// Assertion macros shared by the resampler RTL.
// Each expects clk and arst_n in the scope of the module that uses it.
`ifndef VARIABLE_RATE_LINEAR_RESAMPLER_CORE_MACROS_SVH
`define VARIABLE_RATE_LINEAR_RESAMPLER_CORE_MACROS_SVH

// cond must hold at every clock edge out of reset
`define VRLR_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// pre in this cycle implies post in this cycle
`define VRLR_ASSERT_IMPLY(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// pre in this cycle implies post in the next cycle
`define VRLR_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== rtl/core/vrlr_pkg.sv =====
// Shared types and constants for the linear interpolation resampler.
// No dependencies; imported by vrlr_front, vrlr_back and the top level.
package vrlr_pkg;

	localparam int SAMPLE_BITS       = 24;
	localparam int FRACTION_BITS_DEF = 16;
	localparam int MAX_RESULTS       = 10;
	localparam int CNT_BITS          = $clog2(MAX_RESULTS);
	localparam int MID_DEPTH         = 2;
	localparam int OUT_DEPTH         = 4;
	localparam int OUT_CNT_BITS      = $clog2(OUT_DEPTH + 1);

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          last_sample;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] out_sample;
		logic                          last_of_run;
	} out_item_t;

	typedef enum logic {
		KIND_PRIME,
		KIND_STEP
	} item_kind_t;

	// request handed from the front end to the interpolation back end
	typedef struct packed {
		item_kind_t                  kind;
		logic signed [SAMPLE_BITS-1:0] prev;
		logic signed [SAMPLE_BITS:0]   diff;
		logic                          last;
	} fb_item_t;

	localparam int FB_BITS  = $bits(fb_item_t);
	localparam int OUT_BITS = $bits(out_item_t);

endpackage

// ===== rtl/core/vrlr_fifo.sv =====
// Small register-based FIFO used between the resampler stages.
// Standalone; no package dependency.
module vrlr_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	input  logic [WIDTH-1:0]                 wr_data,
	output logic                             full,
	input  logic                             pop,
	output logic [WIDTH-1:0]                 rd_data,
	output logic                             empty,
	output logic [$clog2(DEPTH+1)-1:0]       count
);

	localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW       = $clog2(DEPTH + 1);

	logic [WIDTH-1:0]    slots_q [DEPTH];
	logic [PTR_BITS-1:0] wr_q;
	logic [PTR_BITS-1:0] rd_q;
	logic [CW-1:0]       count_q;
	logic                do_push;
	logic                do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = slots_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_q] <= wr_data;
		end
	end

endmodule

// ===== rtl/core/vrlr_front.sv =====
// Front end: accepts source samples, tracks the previous sample and the
// primed flag, and classifies each request. Depends on vrlr_pkg.
module vrlr_front
	import vrlr_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  in_item_t  src,
	input  logic      mid_full,
	output logic      mid_push,
	output fb_item_t  mid_item
);

	logic                          primed_q;
	logic signed [SAMPLE_BITS-1:0] prev_q;
	logic                          accept;

	assign accept   = push && !mid_full;
	assign mid_push = accept;

	always_comb begin
		mid_item.kind = primed_q ? KIND_STEP : KIND_PRIME;
		mid_item.prev = prev_q;
		mid_item.diff = (SAMPLE_BITS+1)'(src.sample) - (SAMPLE_BITS+1)'(prev_q);
		mid_item.last = src.last_sample;
	end

	// a last-flagged sample ends the clip and returns to the unprimed state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q <= 1'b0;
			prev_q   <= '0;
		end else if (accept) begin
			primed_q <= !src.last_sample;
			prev_q   <= src.last_sample ? '0 : src.sample;
		end
	end

endmodule

// ===== rtl/core/vrlr_back.sv =====
// Back end: holds the rate register, read phase and skip count, and runs
// the multiply / add pipeline that produces interpolated results.
// Depends on vrlr_pkg and the shared assertion macros.
`include "variable_rate_linear_resampler_core_macros.svh"

module vrlr_back
	import vrlr_pkg::*;
#(
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       rate_we,
	input  logic [FRACTION_BITS+3:0]   rate_wdata,
	input  fb_item_t                   q_item,
	input  logic                       q_empty,
	output logic                       q_pop,
	input  logic [OUT_CNT_BITS-1:0]    out_count,
	output logic                       out_push,
	output out_item_t                  out_item
);

	localparam int RB = FRACTION_BITS + 4;
	localparam int PW = SAMPLE_BITS + FRACTION_BITS + 2;
	localparam logic [RB-1:0] RATE_ONE = RB'(64'd1 << FRACTION_BITS);
	localparam logic [RB-1:0] RATE_MIN = RB'(((64'd1 << FRACTION_BITS) + 64'd5) / 64'd10);
	localparam logic [RB-1:0] RATE_MAX = RB'(64'd10 << FRACTION_BITS);

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	state_t                        state_q;
	logic [RB-1:0]                 rate_q;
	logic [FRACTION_BITS-1:0]      phase_q;
	logic [3:0]                    skip_q;
	logic [CNT_BITS-1:0]           cnt_q;
	logic                          valid_s1;

	logic signed [SAMPLE_BITS-1:0] prev_q;
	logic signed [SAMPLE_BITS:0]   diff_q;
	logic                          last_q;
	logic signed [PW-1:0]          prod_s1;
	logic signed [SAMPLE_BITS-1:0] prev_s1;
	logic                          last_s1;

	logic [RB-1:0]                 rate_clamped;
	logic [RB-1:0]                 pos;
	logic [3:0]                    whole;
	logic                          done;
	logic                          credit_ok;
	logic                          issue;
	logic signed [PW-1:0]          diff_x;
	logic signed [PW-1:0]          phase_x;
	logic signed [PW-1:0]          prod;
	logic signed [PW-1:0]          bias;
	logic signed [PW-1:0]          term;
	logic signed [PW-1:0]          val;

	always_comb begin
		rate_clamped = rate_wdata;
		if (rate_wdata < RATE_MIN) begin
			rate_clamped = RATE_MIN;
		end
		if (rate_wdata > RATE_MAX) begin
			rate_clamped = RATE_MAX;
		end
	end

	assign pos   = RB'(phase_q) + rate_q;
	assign whole = pos[RB-1:FRACTION_BITS];
	assign done  = (whole != '0) || (cnt_q == CNT_BITS'(MAX_RESULTS - 1));

	// reserve a slot for the result still in the multiply stage
	assign credit_ok = ((OUT_CNT_BITS+1)'(out_count) + (OUT_CNT_BITS+1)'(valid_s1))
		< (OUT_CNT_BITS+1)'(OUT_DEPTH);
	assign issue = (state_q == ST_RUN) && credit_ok;
	assign q_pop = (state_q == ST_IDLE) && !q_empty;

	assign diff_x  = PW'(diff_q);
	assign phase_x = $signed(PW'({1'b0, phase_q}));
	assign prod    = diff_x * phase_x;

	// shift right with truncation toward zero
	assign bias = prod_s1[PW-1] ? $signed({{(PW-FRACTION_BITS){1'b0}}, {FRACTION_BITS{1'b1}}})
		: '0;
	assign term = (prod_s1 + bias) >>> FRACTION_BITS;
	assign val  = PW'(prev_s1) + term;

	assign out_push             = valid_s1;
	assign out_item.out_sample  = val[SAMPLE_BITS-1:0];
	assign out_item.last_of_run = last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rate_q   <= RATE_ONE;
			phase_q  <= '0;
			skip_q   <= '0;
			cnt_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (rate_we) begin
				rate_q <= rate_clamped;
			end
			valid_s1 <= issue;
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						if (q_item.kind == KIND_PRIME) begin
							phase_q <= '0;
							skip_q  <= '0;
						end else if (skip_q != '0) begin
							if (q_item.last) begin
								phase_q <= '0;
								skip_q  <= '0;
							end else begin
								skip_q <= skip_q - 1'b1;
							end
						end else begin
							state_q <= ST_RUN;
							cnt_q   <= '0;
						end
					end
				end
				ST_RUN: begin
					if (credit_ok) begin
						cnt_q <= cnt_q + 1'b1;
						if (done) begin
							state_q <= ST_IDLE;
						end
						if (done && last_q) begin
							phase_q <= '0;
							skip_q  <= '0;
						end else begin
							phase_q <= pos[FRACTION_BITS-1:0];
							if (whole != '0) begin
								skip_q <= whole - 1'b1;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			prev_q <= q_item.prev;
			diff_q <= q_item.diff;
			last_q <= q_item.last;
		end
		if (issue) begin
			prod_s1 <= prod;
			prev_s1 <= prev_q;
			last_s1 <= done;
		end
	end

	`VRLR_ASSERT_IMPLY(a_no_overflow, valid_s1, out_count < OUT_CNT_BITS'(OUT_DEPTH), "overflow")
	`VRLR_ASSERT_IMPLY(a_pop_when_idle, q_pop, state_q == ST_IDLE, "request taken during a run")
	`VRLR_ASSERT_ALWAYS(a_skip_range, skip_q <= 4'd9, "skip count out of range")
	`VRLR_ASSERT_IMPLY(a_cnt_range, state_q == ST_RUN, cnt_q < CNT_BITS'(MAX_RESULTS), "run too long")
	`VRLR_ASSERT_NEXT(a_run_end, issue && done, valid_s1 && last_s1 && state_q == ST_IDLE, "no run end")

endmodule

// ===== rtl/core/variable_rate_linear_resampler_core.sv =====
// Linear interpolation resampler. A source sample is accepted when push is
// high and full is low; interpolated results leave through empty/pop in the
// order they are made. The first sample of a clip only primes the block; a
// sample whose read positions are all skipped is taken without a result;
// any other sample starts a run of results (up to ten at the slowest rate),
// paced by the single multiplier of the back end. A two-entry
// request queue lets new samples in while a run is in progress, and a
// four-entry result queue holds finished results until they are popped.
// rate_wdata (unsigned Q4.FRACTION_BITS) is clamped to 0.1 .. 10 on write
// and should only change while no sample is in flight.
// Depends on vrlr_pkg, vrlr_fifo, vrlr_front and vrlr_back.
`include "variable_rate_linear_resampler_core_macros.svh"

module variable_rate_linear_resampler_core
	import vrlr_pkg::*;
#(
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	input  in_item_t                 src,
	output logic                     full,
	output logic                     empty,
	input  logic                     pop,
	output out_item_t                res,
	input  logic                     rate_we,
	input  logic [FRACTION_BITS+3:0] rate_wdata
);

	localparam int MID_CW = $clog2(MID_DEPTH + 1);

	logic                              mid_push;
	fb_item_t                          mid_wr;
	logic [FB_BITS-1:0]                mid_rd;
	fb_item_t                          mid_item;
	logic                              mid_empty;
	logic                              mid_pop;
	logic [MID_CW-1:0]                 mid_count;
	logic                              out_push;
	out_item_t                         out_wr;
	logic [OUT_BITS-1:0]               out_rd;
	logic [OUT_CNT_BITS-1:0]           out_count;
	logic                              out_full;

	assign mid_item = fb_item_t'(mid_rd);
	assign res      = out_item_t'(out_rd);

	vrlr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.src      (src),
		.mid_full (full),
		.mid_push (mid_push),
		.mid_item (mid_wr)
	);

	vrlr_fifo #(
		.WIDTH (FB_BITS),
		.DEPTH (MID_DEPTH)
	) u_mid_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (mid_push),
		.wr_data (mid_wr),
		.full    (full),
		.pop     (mid_pop),
		.rd_data (mid_rd),
		.empty   (mid_empty),
		.count   (mid_count)
	);

	vrlr_back #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.rate_we    (rate_we),
		.rate_wdata (rate_wdata),
		.q_item     (mid_item),
		.q_empty    (mid_empty),
		.q_pop      (mid_pop),
		.out_count  (out_count),
		.out_push   (out_push),
		.out_item   (out_wr)
	);

	vrlr_fifo #(
		.WIDTH (OUT_BITS),
		.DEPTH (OUT_DEPTH)
	) u_out_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (out_push),
		.wr_data (out_wr),
		.full    (out_full),
		.pop     (pop),
		.rd_data (out_rd),
		.empty   (empty),
		.count   (out_count)
	);

	// queue bookkeeping checks
	`VRLR_ASSERT_IMPLY(a_mid_count, full, mid_count == MID_CW'(MID_DEPTH), "request count mismatch")
	`VRLR_ASSERT_IMPLY(a_out_room, out_push, !out_full, "result written into a full queue")
	`VRLR_ASSERT_NEXT(a_full_hold, full && !mid_pop, full, "request queue drained without a pop")

endmodule
